// ===== hdl/bhrs_pkg.sv =====
// ----------------------------------------------------------------------------
// bhrs_pkg
// Shared types and constants of the best hit random selector: read type codes,
// default parameter values and the entry passed from front to back end.
// ----------------------------------------------------------------------------
package bhrs_pkg;

  localparam int MAX_GROUP_DEF     = 1024;
  localparam int POSITION_BITS_DEF = 36;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [1:0] RT_NONE   = 2'd0;
  localparam logic [1:0] RT_UNIQUE = 2'd1;
  localparam logic [1:0] RT_REPEAT = 2'd2;

  typedef struct packed {
    logic [7:0] mismatches;
    logic [7:0] gap_opens;
    logic [7:0] gap_extends;
    logic       strand;
  } details_t;

  typedef struct packed {
    logic        is_end;
    logic        nonempty;
    logic [31:0] cnt_best;
    logic [31:0] cnt_other;
    logic [31:0] prior;
    logic [37:0] weight;
    logic [36:0] size;
    logic [35:0] lo;
    logic [31:0] pick_rnd;
    logic [31:0] off_rnd;
    logic [9:0]  index;
    logic [15:0] score;
    details_t    det;
  } entry_t;

endpackage

// ===== hdl/best_hit_random_selector_core.sv =====
// ----------------------------------------------------------------------------
// best_hit_random_selector_core
// Weighted random choice of one best-score hit from a sorted group of records.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while the queue is not full, records
// and end-of-group items alike. The front end keeps the best-score run and
// the saturating counts in registers, and passes best-run records and group
// ends through a four-entry queue to the back end, where the replace decision
// and the position pick run in two stages on 32-bit partial products. A group
// end goes through the queue and a stage register to the output register,
// where its result waits while later items keep arriving until the queue fills.
// ----------------------------------------------------------------------------
module best_hit_random_selector_core
  import bhrs_pkg::*;
#(
  parameter int MAX_GROUP     = MAX_GROUP_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [15:0] in_score,
  input  logic [35:0] in_interval_low,
  input  logic [35:0] in_interval_high,
  input  logic [7:0]  in_mismatches,
  input  logic [7:0]  in_gap_opens,
  input  logic [7:0]  in_gap_extends,
  input  logic        in_strand,
  input  logic [31:0] in_pick_random,
  input  logic [31:0] in_offset_random,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_read_type,
  output logic [31:0] out_best_count,
  output logic [31:0] out_other_count,
  output logic [9:0]  out_chosen_index,
  output logic [35:0] out_chosen_position,
  output logic [15:0] out_chosen_score,
  output logic [7:0]  out_chosen_mismatches,
  output logic [7:0]  out_chosen_gap_opens,
  output logic [7:0]  out_chosen_gap_extends,
  output logic        out_chosen_strand
);

  logic   q_full, q_push, q_pop, q_valid;
  entry_t push_entry, head_entry;

  bhrs_front #(
    .MAX_GROUP     (MAX_GROUP),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_score         (in_score),
    .in_interval_low  (in_interval_low),
    .in_interval_high (in_interval_high),
    .in_mismatches    (in_mismatches),
    .in_gap_opens     (in_gap_opens),
    .in_gap_extends   (in_gap_extends),
    .in_strand        (in_strand),
    .in_pick_random   (in_pick_random),
    .in_offset_random (in_offset_random),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_entry          (push_entry)
  );

  bhrs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (head_entry)
  );

  bhrs_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .q_valid                (q_valid),
    .q_entry                (head_entry),
    .q_pop                  (q_pop),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_read_type          (out_read_type),
    .out_best_count         (out_best_count),
    .out_other_count        (out_other_count),
    .out_chosen_index       (out_chosen_index),
    .out_chosen_position    (out_chosen_position),
    .out_chosen_score       (out_chosen_score),
    .out_chosen_mismatches  (out_chosen_mismatches),
    .out_chosen_gap_opens   (out_chosen_gap_opens),
    .out_chosen_gap_extends (out_chosen_gap_extends),
    .out_chosen_strand      (out_chosen_strand)
  );

endmodule

// ===== hdl/bhrs_front.sv =====
// ----------------------------------------------------------------------------
// bhrs_front
// Takes records and end-of-group items, tracks the best-score run and the
// saturating occurrence counts, and queues best-run records and group ends.
// ----------------------------------------------------------------------------
module bhrs_front
  import bhrs_pkg::*;
#(
  parameter int MAX_GROUP     = MAX_GROUP_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [15:0] in_score,
  input  logic [35:0] in_interval_low,
  input  logic [35:0] in_interval_high,
  input  logic [7:0]  in_mismatches,
  input  logic [7:0]  in_gap_opens,
  input  logic [7:0]  in_gap_extends,
  input  logic        in_strand,
  input  logic [31:0] in_pick_random,
  input  logic [31:0] in_offset_random,
  input  logic        q_full,
  output logic        q_push,
  output entry_t      q_entry
);

  localparam int CW = $clog2(MAX_GROUP + 1);
  localparam int EB = (POSITION_BITS < 36) ? POSITION_BITS : 36;
  localparam logic [36:0] ONE_SH = 37'(1) << EB;
  localparam logic [35:0] POS_MASK = 36'(ONE_SH - 37'(1));

  logic          nonempty_r, nonempty_nxt;
  logic [15:0]   best_score_r, best_score_nxt;
  logic          past_r, past_nxt;
  logic [31:0]   best_r, best_nxt;
  logic [31:0]   total_r, total_nxt;
  logic [CW-1:0] rec_cnt_r, rec_cnt_nxt;

  logic        accept, rec_ok, is_best;
  logic [35:0] lo, hi, hi_eff;
  logic [36:0] size;
  logic [15:0] base_score;
  logic        past_now;
  logic [37:0] best_sum, total_sum;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign rec_ok   = accept && !in_mode && (rec_cnt_r < CW'(MAX_GROUP));

  always_comb begin
    lo         = in_interval_low & POS_MASK;
    hi         = in_interval_high & POS_MASK;
    hi_eff     = (hi < lo) ? lo : hi;
    size       = {1'b0, hi_eff} - {1'b0, lo} + 37'd1;
    base_score = nonempty_r ? best_score_r : in_score;
    past_now   = (nonempty_r && past_r) || (in_score > base_score);
    is_best    = !past_now;
    best_sum   = {6'd0, best_r} + {1'b0, size};
    total_sum  = {6'd0, total_r} + {1'b0, size};
  end

  always_comb begin
    nonempty_nxt   = nonempty_r;
    best_score_nxt = best_score_r;
    past_nxt       = past_r;
    best_nxt       = best_r;
    total_nxt      = total_r;
    rec_cnt_nxt    = rec_cnt_r;
    if (accept && in_mode) begin
      nonempty_nxt   = 1'b0;
      best_score_nxt = '0;
      past_nxt       = 1'b0;
      best_nxt       = '0;
      total_nxt      = '0;
      rec_cnt_nxt    = '0;
    end else if (rec_ok) begin
      nonempty_nxt   = 1'b1;
      best_score_nxt = base_score;
      past_nxt       = past_now;
      if (is_best) begin
        best_nxt = (best_sum[37:32] != 6'd0) ? 32'hFFFF_FFFF : best_sum[31:0];
      end
      total_nxt   = (total_sum[37:32] != 6'd0) ? 32'hFFFF_FFFF : total_sum[31:0];
      rec_cnt_nxt = rec_cnt_r + CW'(1);
    end
  end

  always_comb begin
    q_push                  = (accept && in_mode) || (rec_ok && is_best);
    q_entry.is_end          = in_mode;
    q_entry.nonempty        = nonempty_r;
    q_entry.cnt_best        = best_r;
    q_entry.cnt_other       = total_r - best_r;
    q_entry.prior           = best_r;
    q_entry.weight          = best_sum;
    q_entry.size            = size;
    q_entry.lo              = lo;
    q_entry.pick_rnd        = in_pick_random;
    q_entry.off_rnd         = in_offset_random;
    q_entry.index           = 10'(rec_cnt_r);
    q_entry.score           = in_score;
    q_entry.det.mismatches  = in_mismatches;
    q_entry.det.gap_opens   = in_gap_opens;
    q_entry.det.gap_extends = in_gap_extends;
    q_entry.det.strand      = in_strand;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonempty_r   <= 1'b0;
      best_score_r <= '0;
      past_r       <= 1'b0;
      best_r       <= '0;
      total_r      <= '0;
      rec_cnt_r    <= '0;
    end else begin
      nonempty_r   <= nonempty_nxt;
      best_score_r <= best_score_nxt;
      past_r       <= past_nxt;
      best_r       <= best_nxt;
      total_r      <= total_nxt;
      rec_cnt_r    <= rec_cnt_nxt;
    end
  end

endmodule

// ===== hdl/bhrs_queue.sv =====
// ----------------------------------------------------------------------------
// bhrs_queue
// Small first-in first-out queue of entries between front and back end.
// ----------------------------------------------------------------------------
module bhrs_queue
  import bhrs_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head_entry
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  entry_t      slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r, count_nxt;

  assign full       = (count_r == (PW+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (PW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hdl/bhrs_back.sv =====
// ----------------------------------------------------------------------------
// bhrs_back
// Replace decision and position pick for best-run records in two stages,
// holding the current pick, and result register for group ends.
// ----------------------------------------------------------------------------
module bhrs_back
  import bhrs_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  entry_t      q_entry,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_read_type,
  output logic [31:0] out_best_count,
  output logic [31:0] out_other_count,
  output logic [9:0]  out_chosen_index,
  output logic [35:0] out_chosen_position,
  output logic [15:0] out_chosen_score,
  output logic [7:0]  out_chosen_mismatches,
  output logic [7:0]  out_chosen_gap_opens,
  output logic [7:0]  out_chosen_gap_extends,
  output logic        out_chosen_strand
);

  localparam int EB = (POSITION_BITS < 36) ? POSITION_BITS : 36;
  localparam logic [36:0] ONE_SH = 37'(1) << EB;
  localparam logic [35:0] POS_MASK = 36'(ONE_SH - 37'(1));

  logic        adv;
  logic        a_valid_r;
  entry_t      a_entry_r;
  logic [63:0] p0_r, q0_r;
  logic [37:0] p1_r;
  logic [36:0] q1_r;

  logic [38:0] hi_sum;
  logic [37:0] pos_sum;
  logic        take;
  logic [35:0] pos;

  logic [9:0]  pk_index_r;
  logic [35:0] pk_pos_r;
  logic [15:0] pk_score_r;
  details_t    pk_det_r;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  rt_r;
  logic [31:0] bc_r, oc_r;
  logic [9:0]  ci_r;
  logic [35:0] cp_r;
  logic [15:0] cs_r;
  details_t    cd_r;

  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && q_valid;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_entry_r <= q_entry;
      p0_r      <= 64'(q_entry.pick_rnd) * 64'(q_entry.weight[31:0]);
      p1_r      <= 38'(q_entry.pick_rnd) * 38'(q_entry.weight[37:32]);
      q0_r      <= 64'(q_entry.off_rnd) * 64'(q_entry.size[31:0]);
      q1_r      <= 37'(q_entry.off_rnd) * 37'(q_entry.size[36:32]);
    end
  end

  always_comb begin
    hi_sum  = {1'b0, p1_r} + {7'd0, p0_r[63:32]};
    take    = (a_entry_r.prior == 32'd0) || (hi_sum > {7'd0, a_entry_r.prior}) ||
              ((hi_sum == {7'd0, a_entry_r.prior}) && (p0_r[31:0] != 32'd0));
    pos_sum = {2'd0, a_entry_r.lo} + {1'b0, q1_r} + {6'd0, q0_r[63:32]};
    pos     = pos_sum[35:0] & POS_MASK;
  end

  always_ff @(posedge clk) begin
    if (adv && a_valid_r && !a_entry_r.is_end && take) begin
      pk_index_r <= a_entry_r.index;
      pk_pos_r   <= pos;
      pk_score_r <= a_entry_r.score;
      pk_det_r   <= a_entry_r.det;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = a_valid_r && a_entry_r.is_end;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && a_valid_r && a_entry_r.is_end) begin
      if (a_entry_r.nonempty) begin
        rt_r <= (a_entry_r.cnt_best > 32'd1) ? RT_REPEAT : RT_UNIQUE;
        bc_r <= a_entry_r.cnt_best;
        oc_r <= a_entry_r.cnt_other;
        ci_r <= pk_index_r;
        cp_r <= pk_pos_r;
        cs_r <= pk_score_r;
        cd_r <= pk_det_r;
      end else begin
        rt_r <= RT_NONE;
        bc_r <= '0;
        oc_r <= '0;
        ci_r <= '0;
        cp_r <= '0;
        cs_r <= '0;
        cd_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        a_valid_r <= q_valid;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_read_type          = rt_r;
  assign out_best_count         = bc_r;
  assign out_other_count        = oc_r;
  assign out_chosen_index       = ci_r;
  assign out_chosen_position    = cp_r;
  assign out_chosen_score       = cs_r;
  assign out_chosen_mismatches  = cd_r.mismatches;
  assign out_chosen_gap_opens   = cd_r.gap_opens;
  assign out_chosen_gap_extends = cd_r.gap_extends;
  assign out_chosen_strand      = cd_r.strand;

endmodule

// ===== tb/bhrs_checker.sv =====
// ----------------------------------------------------------------------------
// bhrs_checker
// Watches both channels of the best hit random selector, keeps its own copy of
// the group state, predicts the summary that each group end produces and
// compares every accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bhrs_checker
  import bhrs_pkg::*;
#(
  parameter logic END_MODE = 1'b1
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_mode,
  input  logic [15:0] in_score,
  input  logic [35:0] in_interval_low,
  input  logic [35:0] in_interval_high,
  input  logic [7:0]  in_mismatches,
  input  logic [7:0]  in_gap_opens,
  input  logic [7:0]  in_gap_extends,
  input  logic        in_strand,
  input  logic [31:0] in_pick_random,
  input  logic [31:0] in_offset_random,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_read_type,
  input  logic [31:0] out_best_count,
  input  logic [31:0] out_other_count,
  input  logic [9:0]  out_chosen_index,
  input  logic [35:0] out_chosen_position,
  input  logic [15:0] out_chosen_score,
  input  logic [7:0]  out_chosen_mismatches,
  input  logic [7:0]  out_chosen_gap_opens,
  input  logic [7:0]  out_chosen_gap_extends,
  input  logic        out_chosen_strand,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] COUNT_CEIL  = 64'h0000_0000_FFFF_FFFF;
  localparam int          GROUP_LIMIT = MAX_GROUP_DEF;

  typedef struct {
    logic [1:0]  read_type;
    logic [31:0] best_count;
    logic [31:0] other_count;
    logic [9:0]  index;
    logic [35:0] position;
    logic [15:0] score;
    details_t    det;
  } group_summary_t;

  group_summary_t summary_q[$];
  group_summary_t grp_pick;
  logic           grp_open;
  logic           grp_past_best;
  logic [15:0]    grp_best_score;
  logic [63:0]    best_occ;
  logic [63:0]    total_occ;
  int             grp_records;
  int             mismatch_total = 0;

  function automatic logic [63:0] add_saturating(logic [63:0] acc, logic [36:0] size);
    logic [63:0] sum;
    sum = acc + 64'(size);
    return (sum > COUNT_CEIL) ? COUNT_CEIL : sum;
  endfunction

  task automatic clear_group();
    grp_open       = 1'b0;
    grp_past_best  = 1'b0;
    grp_best_score = '0;
    best_occ       = '0;
    total_occ      = '0;
    grp_records    = 0;
    grp_pick       = '{default: '0};
  endtask

  task automatic take_record();
    logic [35:0] top_end;
    logic [36:0] size;
    logic [71:0] w_size;
    logic [71:0] w_prior;
    logic [71:0] w_rnd;
    logic [71:0] weight;
    logic [71:0] span;
    if (grp_records >= GROUP_LIMIT) return;
    top_end = (in_interval_high < in_interval_low) ? in_interval_low : in_interval_high;
    size    = {1'b0, top_end} - {1'b0, in_interval_low} + 37'd1;
    if (!grp_open) begin
      grp_open       = 1'b1;
      grp_best_score = in_score;
      grp_past_best  = 1'b0;
    end
    if (!grp_past_best && in_score > grp_best_score) grp_past_best = 1'b1;
    if (!grp_past_best) begin
      w_size  = 72'(size);
      w_prior = 72'(best_occ);
      w_rnd   = 72'(in_pick_random);
      weight  = (w_size + w_prior) * w_rnd;
      if (best_occ == 0 || weight > (w_prior << 32)) begin
        grp_pick.index           = grp_records[9:0];
        grp_pick.score           = in_score;
        grp_pick.det.mismatches  = in_mismatches;
        grp_pick.det.gap_opens   = in_gap_opens;
        grp_pick.det.gap_extends = in_gap_extends;
        grp_pick.det.strand      = in_strand;
        w_rnd                    = 72'(in_offset_random);
        span                     = w_size * w_rnd;
        grp_pick.position        = in_interval_low + span[67:32];
      end
      best_occ = add_saturating(best_occ, size);
    end
    total_occ = add_saturating(total_occ, size);
    grp_records++;
  endtask

  task automatic close_group();
    group_summary_t s;
    s           = '{default: '0};
    s.read_type = RT_NONE;
    if (grp_open) begin
      s             = grp_pick;
      s.read_type   = (best_occ > 1) ? RT_REPEAT : RT_UNIQUE;
      s.best_count  = best_occ[31:0];
      s.other_count = total_occ[31:0] - best_occ[31:0];
    end
    summary_q.push_back(s);
    clear_group();
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_total++;
    end
  endtask

  task automatic check_summary();
    group_summary_t s;
    if (summary_q.size() == 0) begin
      $error("result with no group end waiting for it");
      mismatch_total++;
      return;
    end
    s = summary_q.pop_front();
    compare_field("read_type", 64'(s.read_type), 64'(out_read_type));
    compare_field("best_count", 64'(s.best_count), 64'(out_best_count));
    compare_field("other_count", 64'(s.other_count), 64'(out_other_count));
    compare_field("chosen_index", 64'(s.index), 64'(out_chosen_index));
    compare_field("chosen_position", 64'(s.position), 64'(out_chosen_position));
    compare_field("chosen_score", 64'(s.score), 64'(out_chosen_score));
    compare_field("chosen_mismatches", 64'(s.det.mismatches), 64'(out_chosen_mismatches));
    compare_field("chosen_gap_opens", 64'(s.det.gap_opens), 64'(out_chosen_gap_opens));
    compare_field("chosen_gap_extends", 64'(s.det.gap_extends),
                  64'(out_chosen_gap_extends));
    compare_field("chosen_strand", 64'(s.det.strand), 64'(out_chosen_strand));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_group();
      summary_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (in_mode == END_MODE) close_group();
        else take_record();
      end
      if (out_valid && !out_stall) check_summary();
    end
    pending    <= summary_q.size();
    fail_count <= mismatch_total;
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for best_hit_random_selector_core: directed groups for
// the corner cases, then random sorted groups with noise, under several idle
// and stall profiles on both channels. Checking is done in bhrs_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import bhrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_RECORD   = 1'b0;
  localparam logic MODE_END      = 1'b1;
  localparam int   CYCLE_LIMIT   = 1_000_000;
  localparam int   SETTLE_CYCLES = 20;
  localparam int   PHASE_ITEMS   = 40;
  localparam int   LONG_GROUP    = MAX_GROUP_DEF + 6;

  typedef enum logic [1:0] {IDLE_OFF, IDLE_LIGHT, IDLE_HEAVY} idle_level_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] score;
    logic [35:0] lo;
    logic [35:0] hi;
    details_t    det;
    logic [31:0] pick_rnd;
    logic [31:0] off_rnd;
  } hit_request_t;

  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_mode          = 1'b0;
  logic [15:0] in_score         = '0;
  logic [35:0] in_interval_low  = '0;
  logic [35:0] in_interval_high = '0;
  logic [7:0]  in_mismatches    = '0;
  logic [7:0]  in_gap_opens     = '0;
  logic [7:0]  in_gap_extends   = '0;
  logic        in_strand        = 1'b0;
  logic [31:0] in_pick_random   = '0;
  logic [31:0] in_offset_random = '0;
  logic        out_stall        = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  out_read_type;
  logic [31:0] out_best_count;
  logic [31:0] out_other_count;
  logic [9:0]  out_chosen_index;
  logic [35:0] out_chosen_position;
  logic [15:0] out_chosen_score;
  logic [7:0]  out_chosen_mismatches;
  logic [7:0]  out_chosen_gap_opens;
  logic [7:0]  out_chosen_gap_extends;
  logic        out_chosen_strand;

  int          mismatch_count;
  int          groups_in_flight;
  int          cycle_count = 0;
  int          stall_left  = 0;
  int          sent_count  = 0;
  idle_level_t tx_level    = IDLE_LIGHT;
  idle_level_t rx_level    = IDLE_LIGHT;

  always #5 clk = ~clk;

  best_hit_random_selector_core u_top (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_mode, .in_score, .in_interval_low, .in_interval_high,
    .in_mismatches, .in_gap_opens, .in_gap_extends, .in_strand,
    .in_pick_random, .in_offset_random,
    .out_valid, .out_stall, .out_read_type, .out_best_count, .out_other_count,
    .out_chosen_index, .out_chosen_position, .out_chosen_score,
    .out_chosen_mismatches, .out_chosen_gap_opens, .out_chosen_gap_extends,
    .out_chosen_strand
  );

  bhrs_checker #(.END_MODE(MODE_END)) u_checker (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_mode, .in_score, .in_interval_low, .in_interval_high,
    .in_mismatches, .in_gap_opens, .in_gap_extends, .in_strand,
    .in_pick_random, .in_offset_random,
    .out_valid, .out_stall, .out_read_type, .out_best_count, .out_other_count,
    .out_chosen_index, .out_chosen_position, .out_chosen_score,
    .out_chosen_mismatches, .out_chosen_gap_opens, .out_chosen_gap_extends,
    .out_chosen_strand,
    .fail_count(mismatch_count),
    .pending(groups_in_flight)
  );

  function automatic int idle_length(idle_level_t lvl);
    int roll;
    if (lvl == IDLE_OFF) return 0;
    roll = $urandom_range(99, 0);
    if (lvl == IDLE_HEAVY) roll = 50 + roll / 2;
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    if (roll < 98) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  always @(posedge clk) begin
    if (!rst_n || rx_level == IDLE_OFF) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99, 0) < ((rx_level == IDLE_HEAVY) ? 55 : 25)) begin
      out_stall  <= 1'b1;
      stall_left <= idle_length(rx_level);
    end else begin
      out_stall  <= 1'b0;
      stall_left <= $urandom_range(6, 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL best_hit_random_selector_core");
      $finish;
    end
  end

  function automatic hit_request_t make_record(logic mode, logic [15:0] score,
                                               logic [35:0] lo, logic [35:0] hi,
                                               logic [24:0] det, logic [31:0] pick_rnd,
                                               logic [31:0] off_rnd);
    hit_request_t r;
    r.mode     = mode;
    r.score    = score;
    r.lo       = lo;
    r.hi       = hi;
    r.det      = det;
    r.pick_rnd = pick_rnd;
    r.off_rnd  = off_rnd;
    return r;
  endfunction

  function automatic logic [31:0] random_fraction();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 8) return '0;
    if (roll < 16) return '1;
    return $urandom;
  endfunction

  function automatic hit_request_t random_record(logic [15:0] score);
    hit_request_t r;
    logic [63:0]  bits;
    logic [63:0]  span;
    logic [36:0]  top_end;
    int           roll;
    bits       = {$urandom, $urandom};
    r.mode     = MODE_RECORD;
    r.score    = score;
    r.lo       = bits[35:0];
    bits       = {$urandom, $urandom};
    r.det      = bits[24:0];
    r.pick_rnd = random_fraction();
    r.off_rnd  = random_fraction();
    roll = $urandom_range(99, 0);
    if (roll < 4) r.lo = '0;
    else if (roll < 8) r.lo = '1;
    span = {$urandom, $urandom};
    roll = $urandom_range(99, 0);
    if (roll < 60) span = 64'($urandom_range(15, 0));
    else if (roll < 85) span = 64'($urandom_range(1 << 20, 0));
    else if (roll < 93) span = 64'(span[35:0]);
    top_end = {1'b0, r.lo} + 37'(span[35:0]);
    if (roll >= 93) r.hi = bits[60:25];
    else if (top_end[36]) r.hi = '1;
    else r.hi = top_end[35:0];
    return r;
  endfunction

  task automatic push_request(input hit_request_t r);
    int gap;
    in_valid         <= 1'b1;
    in_mode          <= r.mode;
    in_score         <= r.score;
    in_interval_low  <= r.lo;
    in_interval_high <= r.hi;
    in_mismatches    <= r.det.mismatches;
    in_gap_opens     <= r.det.gap_opens;
    in_gap_extends   <= r.det.gap_extends;
    in_strand        <= r.det.strand;
    in_pick_random   <= r.pick_rnd;
    in_offset_random <= r.off_rnd;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    sent_count++;
    gap = idle_length(tx_level);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (groups_in_flight != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_group();
    hit_request_t r;
    logic [15:0]  best;
    logic [15:0]  s;
    int           n_best;
    int           n_worse;
    int           roll;
    bit           noisy;
    roll = $urandom_range(99, 0);
    if (roll < 10) best = '0;
    else if (roll < 18) best = '1;
    else best = 16'($urandom_range(65535, 0));
    roll = $urandom_range(99, 0);
    if (roll < 5) n_best = 0;
    else if (roll < 75) n_best = $urandom_range(3, 1);
    else n_best = $urandom_range(8, 4);
    n_worse = (n_best == 0) ? 0 : $urandom_range(4, 0);
    noisy   = ($urandom_range(99, 0) < 10);
    s       = best;
    for (int i = 0; i < n_best + n_worse; i++) begin
      if (noisy) begin
        s = 16'($urandom_range(65535, 0));
      end else if (i >= n_best) begin
        roll = $urandom_range(300, 1);
        s    = (s > 16'hFFFF - roll) ? 16'hFFFF : 16'(s + roll);
      end
      push_request(random_record(s));
    end
    r      = random_record(16'($urandom_range(65535, 0)));
    r.mode = MODE_END;
    push_request(r);
  endtask

  task automatic long_group();
    hit_request_t r;
    logic [15:0]  s;
    s = 16'($urandom_range(65535, 0));
    for (int i = 0; i < LONG_GROUP; i++) begin
      r    = random_record(s);
      r.hi = r.lo;
      push_request(r);
    end
    r      = random_record(s);
    r.mode = MODE_END;
    push_request(r);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty group
    push_request(make_record(MODE_END, '1, '1, '1, '1, '1, '1));
    // single point hit, zero draw still takes the first record
    push_request(make_record(MODE_RECORD, '0, '0, '0, '1, '0, '1));
    push_request(make_record(MODE_END, '0, '0, '0, '0, '0, '0));
    // reversed interval
    push_request(make_record(MODE_RECORD, '1, '1, '0, '0, '1, '0));
    push_request(make_record(MODE_END, '0, '0, '0, '0, '0, '0));
    // best run, then a worse record ends it and a better one no longer counts
    push_request(make_record(MODE_RECORD, 16'd7, 36'd100, 36'd199, 25'h0A5_5A5, '0, '0));
    push_request(make_record(MODE_RECORD, 16'd7, 36'd1000, 36'd1009, 25'h15A_A5A, '1, '1));
    push_request(make_record(MODE_RECORD, 16'd7, 36'd5000, 36'd5004, 25'h1F0_0F1, '0,
                             32'h8000_0000));
    push_request(make_record(MODE_RECORD, 16'd8, 36'd20, 36'd29, '1, '1, '1));
    push_request(make_record(MODE_RECORD, 16'd3, 36'd40, 36'd49, '1, '1, '1));
    push_request(make_record(MODE_END, '0, '0, '0, '0, '0, '0));
    // saturated counts and a draw exactly at the replace threshold
    push_request(make_record(MODE_RECORD, 16'd5, '0, '1, 25'h0F0_F0F, 32'h8000_0000,
                             32'h4000_0000));
    push_request(make_record(MODE_RECORD, 16'd5, 36'd7, 36'd7, '1, '1, '1));
    push_request(make_record(MODE_RECORD, 16'd9, 36'd10, 36'd19, '1, '1, '1));
    push_request(make_record(MODE_END, '1, '1, '1, '1, '1, '1));
    // huge interval outside the best run
    push_request(make_record(MODE_RECORD, 16'd0, 36'd42, 36'd42, '0, '1, '1));
    push_request(make_record(MODE_RECORD, 16'd1, '0, '1, '0, '1, '1));
    push_request(make_record(MODE_END, '0, '0, '0, '0, '0, '0));
    settle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          tx_level = IDLE_LIGHT;
          rx_level = IDLE_LIGHT;
        end
        1: begin
          tx_level = IDLE_OFF;
          rx_level = IDLE_OFF;
        end
        2: begin
          tx_level = IDLE_LIGHT;
          rx_level = IDLE_HEAVY;
        end
        default: begin
          tx_level = IDLE_HEAVY;
          rx_level = IDLE_LIGHT;
        end
      endcase
      sent_count = 0;
      if (phase == 1) long_group();
      while (sent_count < PHASE_ITEMS + ((phase == 1) ? LONG_GROUP + 1 : 0)) random_group();
      settle();
    end

    if (mismatch_count == 0) begin
      $display("PASS best_hit_random_selector_core");
    end else begin
      $display("FAIL best_hit_random_selector_core");
    end
    $finish;
  end

endmodule
